// File: rtl/core/plc_pkg.sv
// shared types, codes and helpers for the piecewise-linear calibration block
// no dependencies
package plc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int FLAGS_W    = 8;
  localparam int POINTS_W   = 5;
  localparam int SLOT_W     = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 16;
  localparam int PROD_W     = 34;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // request kinds carried in tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_POINTS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEW_GAIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OLD_GAIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLAGS    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK0,
    S_SCAN,
    S_NEXT,
    S_MUL,
    S_DIVS,
    S_DIV,
    S_FIL1,
    S_FIL2,
    S_FIL3,
    S_OUT
  } eng_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic signed [SAMPLE_W-1:0] converted;
  } result_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > PROD_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -PROD_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/plc_bp_mem.sv
// breakpoint table: one synchronous memory holding raw and engineering value per slot
// depends on plc_pkg
module plc_bp_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [plc_pkg::SAMPLE_W-1:0] wr_raw,
  input  logic signed [plc_pkg::SAMPLE_W-1:0] wr_eng,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [plc_pkg::SAMPLE_W-1:0] rd_raw,
  output logic signed [plc_pkg::SAMPLE_W-1:0] rd_eng
);
  import plc_pkg::*;

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [2*SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_eng, wr_raw};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_raw = rd_data_r[SAMPLE_W-1:0];
  assign rd_eng = rd_data_r[2*SAMPLE_W-1:SAMPLE_W];

endmodule

// File: rtl/core/plc_div.sv
// serial restoring divider on magnitudes, one quotient bit per cycle
// depends on plc_pkg
module plc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [plc_pkg::DIV_NUM_W-1:0]  num,
  input  logic [plc_pkg::DIV_DEN_W-1:0]  den,
  output logic [plc_pkg::DIV_NUM_W-1:0]  quo,
  output plc_pkg::div_stat_t             stat
);
  import plc_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W:0]   part;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign part  = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = part >= {1'b0, den_r};
  assign trial = part - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DIV_DEN_W-1:0] : part[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < den_r)
    else $error("divider remainder not reduced");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a run");

endmodule

// File: rtl/core/plc_engine.sv
// conversion sequencer: table search, interpolation, divide and iir filter
// depends on plc_pkg, drives plc_bp_mem and plc_div ports
module plc_engine #(
  parameter int MAX_POINTS = 16,
  parameter int IW         = $clog2(MAX_POINTS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request side
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                req_type,
  input  logic signed [plc_pkg::SAMPLE_W-1:0] sample,
  input  logic [plc_pkg::SLOT_W-1:0]          point_index,
  // configuration
  input  logic [plc_pkg::POINTS_W-1:0]        points_in_use,
  input  logic [plc_pkg::GAIN_W-1:0]          new_gain,
  input  logic [plc_pkg::GAIN_W-1:0]          old_gain,
  // table memory
  output logic                                mem_we,
  output logic [IW-1:0]                       mem_waddr,
  output logic [IW-1:0]                       mem_raddr,
  input  logic signed [plc_pkg::SAMPLE_W-1:0] mem_raw,
  input  logic signed [plc_pkg::SAMPLE_W-1:0] mem_eng,
  // divider
  output logic                                div_start,
  output logic [plc_pkg::DIV_NUM_W-1:0]       div_num,
  output logic [plc_pkg::DIV_DEN_W-1:0]       div_den,
  input  logic [plc_pkg::DIV_NUM_W-1:0]       div_quo,
  input  plc_pkg::div_stat_t                  div_stat,
  // result side
  output logic                                res_valid,
  input  logic                                res_ready,
  output plc_pkg::result_t                    res
);
  import plc_pkg::*;

  localparam int NW = (IW + 1 > POINTS_W) ? IW + 1 : POINTS_W;

  eng_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] x_r, x0_r, y0_r, conv_r, fm_r;
  logic signed [SAMPLE_W:0]   dx_r, dy_r, den_r, den_w;
  logic [IW-1:0]              i_r;
  logic signed [PROD_W-1:0]   prod_r, acc_r, prod_w;
  logic signed [SAMPLE_W:0]   mul_a, mul_b;
  logic                       q_neg_r;
  logic [NW-1:0]              pts_w;
  logic [IW-1:0]              seg_top;
  logic                       hit;
  logic                       req_acc;
  logic [PROD_W-1:0]          prod_mag;
  logic signed [PROD_W-1:0]   q_signed;
  logic signed [SAMPLE_W-1:0] conv_div;
  logic signed [SAMPLE_W-1:0] filt_w;

  // clamp the point count to between 2 and the table size
  always_comb begin
    pts_w = NW'(points_in_use);
    if (pts_w < NW'(2)) begin
      pts_w = NW'(2);
    end else if (pts_w > NW'(MAX_POINTS)) begin
      pts_w = NW'(MAX_POINTS);
    end
  end
  assign seg_top = IW'(pts_w - NW'(2));

  assign req_acc = req_valid && req_ready;
  assign hit     = (i_r == '0) || (x_r >= mem_raw);
  assign den_w   = {mem_raw[SAMPLE_W-1], mem_raw} - {x0_r[SAMPLE_W-1], x0_r};

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_FIL1: begin
        mul_a = {1'b0, new_gain};
        mul_b = {conv_r[SAMPLE_W-1], conv_r};
      end
      S_FIL2: begin
        mul_a = {1'b0, old_gain};
        mul_b = {fm_r[SAMPLE_W-1], fm_r};
      end
      default: begin
        mul_a = dx_r;
        mul_b = dy_r;
      end
    endcase
  end
  assign prod_w = mul_a * mul_b;

  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign div_num  = prod_mag[DIV_NUM_W-1:0];
  assign div_den  = den_r[SAMPLE_W] ? DIV_DEN_W'(-den_r) : den_r[DIV_DEN_W-1:0];

  assign q_signed = q_neg_r ? -PROD_W'({2'b00, div_quo}) : PROD_W'({2'b00, div_quo});
  assign conv_div = sat16(PROD_W'(y0_r) + q_signed);
  assign filt_w   = sat16(acc_r >>> 16);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_acc && req_type == REQ_SAMPLE) begin
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: state_nxt = (x_r <= mem_raw) ? S_FIL1 : S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: state_nxt = (den_w == '0) ? S_FIL1 : S_MUL;
      S_MUL:  state_nxt = S_DIVS;
      S_DIVS: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIL1;
        end
      end
      S_FIL1: state_nxt = S_FIL2;
      S_FIL2: state_nxt = S_FIL3;
      S_FIL3: state_nxt = S_OUT;
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = '0;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        mem_we    = req_valid && req_type == REQ_LOAD
                    && (32'(point_index) < MAX_POINTS);
      end
      S_CHK0: mem_raddr = seg_top;
      S_SCAN: mem_raddr = hit ? i_r + IW'(1) : i_r - IW'(1);
      S_DIVS: div_start = 1'b1;
      S_OUT:  res_valid = 1'b1;
      default: ;
    endcase
  end
  assign mem_waddr = IW'(point_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fm_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && res_ready) begin
        fm_r <= filt_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: x_r <= sample;
      S_CHK0: begin
        conv_r <= mem_eng;
        i_r    <= seg_top;
      end
      S_SCAN: begin
        if (hit) begin
          x0_r <= mem_raw;
          y0_r <= mem_eng;
        end else begin
          i_r <= i_r - IW'(1);
        end
      end
      S_NEXT: begin
        dx_r   <= {x_r[SAMPLE_W-1], x_r} - {x0_r[SAMPLE_W-1], x0_r};
        dy_r   <= {mem_eng[SAMPLE_W-1], mem_eng} - {y0_r[SAMPLE_W-1], y0_r};
        den_r  <= den_w;
        conv_r <= y0_r;
      end
      S_MUL: begin
        prod_r  <= prod_w;
        q_neg_r <= prod_w[PROD_W-1] ^ den_r[SAMPLE_W];
      end
      S_DIV: begin
        if (div_stat.done) begin
          conv_r <= conv_div;
        end
      end
      S_FIL1: prod_r <= prod_w;
      S_FIL2: begin
        prod_r <= prod_w;
        acc_r  <= prod_r;
      end
      S_FIL3: acc_r <= acc_r + prod_r;
      default: ;
    endcase
  end

  assign res.filtered  = filt_w;
  assign res.converted = conv_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> i_r <= seg_top)
    else $error("segment index past the table");

  a_fm_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    fm_r != $past(fm_r) |-> $past(res_valid && res_ready))
    else $error("filter state changed without a result");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !div_stat.done |-> div_stat.busy)
    else $error("waiting on an idle divider");

endmodule

// File: rtl/core/piecewise_linear_calibrate_iir.sv
// Converts raw signed samples to engineering values through a breakpoint table
// (linear interpolation, extrapolation on the last segment) and smooths them with
// a first-order IIR filter. A load request (tuser 1) writes one breakpoint and gives no
// result. A convert request (tuser 0) above the first breakpoint scans the table
// downward from the top segment, 1 to the clamped point count minus 1 entries, and
// then divides on the serial divider. A sample at or below the first breakpoint, or
// on a segment with equal raw ends, skips the divide. The next request is taken
// while a finished result waits in the output register.
// Breakpoints must be loaded before they are used; the table is not cleared.
// depends on plc_pkg, plc_bp_mem, plc_div, plc_engine
module piecewise_linear_calibrate_iir #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample[15:0], point_index[19:16], point_raw[35:20], point_value[51:36]
  input  logic [plc_pkg::IN_DATA_W-1:0]         in_tdata,
  // req_type
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // filtered_out[15:0], converted_out[31:16], flags_out[39:32]
  output logic [plc_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [plc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import plc_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  logic [POINTS_W-1:0] points_r;
  logic [GAIN_W-1:0]   new_gain_r;
  logic [GAIN_W-1:0]   old_gain_r;
  logic [FLAGS_W-1:0]  flags_r;

  logic                       mem_we;
  logic [IW-1:0]              mem_waddr, mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_raw, mem_eng;
  logic                       div_start;
  logic [DIV_NUM_W-1:0]       div_num, div_quo;
  logic [DIV_DEN_W-1:0]       div_den;
  div_stat_t                  div_stat;
  logic                       res_valid, res_ready;
  result_t                    res;

  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r   <= POINTS_W'(2);
      new_gain_r <= '1;
      old_gain_r <= '0;
      flags_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_POINTS:   points_r   <= cfg_wdata[POINTS_W-1:0];
        CFG_NEW_GAIN: new_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_OLD_GAIN: old_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_FLAGS:    flags_r    <= cfg_wdata[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  plc_engine #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_tvalid),
    .req_ready     (in_tready),
    .req_type      (in_tuser),
    .sample        (in_tdata[15:0]),
    .point_index   (in_tdata[19:16]),
    .points_in_use (points_r),
    .new_gain      (new_gain_r),
    .old_gain      (old_gain_r),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .mem_raw       (mem_raw),
    .mem_eng       (mem_eng),
    .div_start     (div_start),
    .div_num       (div_num),
    .div_den       (div_den),
    .div_quo       (div_quo),
    .div_stat      (div_stat),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  plc_bp_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IW)
  ) u_bp_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_raw  (in_tdata[35:20]),
    .wr_eng  (in_tdata[51:36]),
    .rd_addr (mem_raddr),
    .rd_raw  (mem_raw),
    .rd_eng  (mem_eng)
  );

  plc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // output register frees the engine for the next request
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {flags_r, res.converted, res.filtered};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: dv/tb_piecewise_linear_calibrate_iir.sv
`timescale 1ns / 1ps
// self-checking bench for piecewise_linear_calibrate_iir: breakpoint loads and sample
// conversions under several register settings, checked against an in-bench predictor
// depends on plc_pkg and the rtl of the block
module tb_piecewise_linear_calibrate_iir;
  import plc_pkg::*;

  localparam int MAX_POINTS      = 16;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_COUNT     = 6;
  localparam int ITEMS_PER_PHASE = 130;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic signed [SAMPLE_W-1:0] converted;
    logic [FLAGS_W-1:0]         flags;
  } calib_result_t;

  // tracks table, registers and filter memory; queues predicted results
  class calib_tracker;
    int unsigned   points_in_use;
    int unsigned   new_gain;
    int unsigned   old_gain;
    int unsigned   use_flags;
    int            bp_raw[MAX_POINTS];
    int            bp_eng[MAX_POINTS];
    int            filter_mem;
    calib_result_t pending_results[$];
    int            mismatches;
    int            samples_converted;
    int            breakpoints_loaded;

    function new();
      points_in_use = 2;
      new_gain = 65535;
      old_gain = 0;
      use_flags = 0;
      filter_mem = 0;
      mismatches = 0;
      samples_converted = 0;
      breakpoints_loaded = 0;
      foreach (bp_raw[k]) begin
        bp_raw[k] = 0;
        bp_eng[k] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
      case (addr)
        CFG_POINTS:   points_in_use = val[POINTS_W-1:0];
        CFG_NEW_GAIN: new_gain = val;
        CFG_OLD_GAIN: old_gain = val;
        CFG_FLAGS:    use_flags = val[FLAGS_W-1:0];
        default: ;
      endcase
    endfunction

    function int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int convert_raw(int x);
      int     n;
      int     i;
      longint num;
      longint den;
      n = points_in_use;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (x <= bp_raw[0]) return bp_eng[0];
      // top segment first, falls back to segment 0
      for (i = n - 2; i > 0 && x < bp_raw[i]; i--) ;
      den = longint'(bp_raw[i + 1]) - longint'(bp_raw[i]);
      if (den == 0) return bp_eng[i];
      num = longint'(x - bp_raw[i]) * (longint'(bp_eng[i + 1]) - longint'(bp_eng[i]));
      return clip16(longint'(bp_eng[i]) + num / den);
    endfunction

    function void take_request(logic kind, logic [IN_DATA_W-1:0] word);
      calib_result_t want;
      int            conv;
      longint        acc;
      int            slot;
      if (kind == REQ_LOAD) begin
        slot = word[19:16];
        bp_raw[slot] = $signed(word[35:20]);
        bp_eng[slot] = $signed(word[51:36]);
        breakpoints_loaded++;
      end else begin
        conv = convert_raw($signed(word[15:0]));
        acc = longint'(new_gain) * conv + longint'(old_gain) * filter_mem;
        // arithmetic shift floors, as the filter needs
        filter_mem = clip16(acc >>> 16);
        want.filtered = filter_mem[15:0];
        want.converted = conv[15:0];
        want.flags = use_flags[FLAGS_W-1:0];
        pending_results.push_back(want);
        samples_converted++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      calib_result_t want;
      if (pending_results.size() == 0) begin
        $error("result %h arrived with no request pending", word);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if ($signed(word[15:0]) !== want.filtered) begin
        $error("filtered_out: expected %0d, got %0d", want.filtered, $signed(word[15:0]));
        mismatches++;
      end
      if ($signed(word[31:16]) !== want.converted) begin
        $error("converted_out: expected %0d, got %0d", want.converted, $signed(word[31:16]));
        mismatches++;
      end
      if (word[39:32] !== want.flags) begin
        $error("flags_out: expected %0d, got %0d", want.flags, word[39:32]);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  calib_tracker calib = new();
  int           idle_pct = 9;
  int           quiet_cycles = 0;
  int           settings_applied = 0;

  piecewise_linear_calibrate_iir #(
    .MAX_POINTS(MAX_POINTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) calib.take_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) calib.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] load_word(int slot, int raw, int val);
    logic [15:0] r;
    logic [15:0] v;
    logic [3:0]  s;
    r = raw[15:0];
    v = val[15:0];
    s = slot[3:0];
    return {4'h0, v, r, s, 16'h0000};
  endfunction

  // unused fields of a convert request carry junk
  function automatic logic [IN_DATA_W-1:0] sample_word(int x);
    logic [63:0] junk;
    logic [15:0] smp;
    junk = {$urandom, $urandom};
    smp = x[15:0];
    return {4'h0, junk[35:0], smp};
  endfunction

  function automatic int random_word16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_sample();
    int k;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2, 3, 4: begin
        k = $urandom_range(0, MAX_POINTS - 1);
        return calib.bp_raw[k] + int'($urandom_range(0, 6)) - 3;
      end
      default: return random_word16();
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic [IN_DATA_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // the edge after the last handshake lets the monitor queue it first
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (calib.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    calib.write_reg(addr, val);
    @(posedge clk);
  endtask

  task automatic apply_config(input int pts, input int ng, input int og, input int fl);
    cfg_write(CFG_POINTS, pts[CFG_DATA_W-1:0]);
    cfg_write(CFG_NEW_GAIN, ng[CFG_DATA_W-1:0]);
    cfg_write(CFG_OLD_GAIN, og[CFG_DATA_W-1:0]);
    cfg_write(CFG_FLAGS, fl[CFG_DATA_W-1:0]);
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  // ascending raw values with random spread, sometimes with a flat segment
  task automatic load_sorted_table();
    int raws[$];
    int spread;
    int k;
    case ($urandom_range(0, 2))
      0: spread = 65535;
      1: spread = 4000;
      default: spread = 300;
    endcase
    for (k = 0; k < MAX_POINTS; k++) begin
      raws.push_back(int'($urandom_range(0, spread)) - spread / 2);
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, MAX_POINTS - 2);
      raws[k + 1] = raws[k];
    end
    raws.sort();
    for (k = 0; k < MAX_POINTS; k++) begin
      send_request(REQ_LOAD, load_word(k, raws[k], random_word16()));
    end
  endtask

  task automatic run_directed();
    int k;
    int val;
    // evenly spaced table from -32768 up to 32767
    for (k = 0; k < MAX_POINTS; k++) begin
      if (k == 0) val = 32767;
      else if (k == 1) val = -32768;
      else val = k * 3000 - 20000;
      send_request(REQ_LOAD, load_word(k, -32768 + k * 4369, val));
    end
    // two points in use: at the first point, first segment, extrapolation at full scale and mid-scale
    send_request(REQ_SAMPLE, sample_word(-32768));
    send_request(REQ_SAMPLE, sample_word(-32767));
    send_request(REQ_SAMPLE, sample_word(32767));
    send_request(REQ_SAMPLE, sample_word(0));
    wait_idle();
    // point count above the table size
    apply_config(31, 65535, 0, 8'hA5);
    send_request(REQ_SAMPLE, sample_word(32767));
    send_request(REQ_SAMPLE, sample_word(-32768));
    send_request(REQ_SAMPLE, sample_word(12345));
    // flat top segment returns its start value
    send_request(REQ_LOAD, load_word(MAX_POINTS - 1, -32768 + 14 * 4369, 7));
    send_request(REQ_SAMPLE, sample_word(32767));
  endtask

  initial begin
    int phase;
    int n;
    int slot;
    int raw;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_SAMPLE;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_POINTS;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      idle_pct = (phase == 1) ? 0 : 9;
      case (phase)
        0: apply_config(16, 32768, 32768, $urandom_range(0, 255));
        1: apply_config(0, 0, 65535, $urandom_range(0, 255));
        2: apply_config(1, 65535, 65535, $urandom_range(0, 255));
        3: apply_config($urandom_range(2, 16), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255));
        4: apply_config(31, $urandom_range(0, 65535), $urandom_range(0, 65535), 255);
        default: apply_config($urandom_range(0, 31), $urandom_range(0, 65535), 0, 0);
      endcase
      load_sorted_table();
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          // either a fresh point anywhere or a new value on the old raw position
          slot = $urandom_range(0, MAX_POINTS - 1);
          raw = $urandom_range(0, 1) ? random_word16() : calib.bp_raw[slot];
          send_request(REQ_LOAD, load_word(slot, raw, random_word16()));
        end else begin
          send_request(REQ_SAMPLE, sample_word(pick_sample()));
        end
      end
    end

    idle_pct = 9;
    wait_idle();
    $display("%0d samples converted, %0d breakpoints loaded, %0d register settings",
             calib.samples_converted, calib.breakpoints_loaded, settings_applied);
    $display("point counts 0 to 31, gain extremes, flat and unordered segments; %0d mismatches",
             calib.mismatches);
    if (calib.mismatches == 0 && calib.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
